[rtl/spq_pkg.sv]
// Package for the sorted priority queue: sizes, opcodes, status codes and the
// control bundle that the top level broadcasts to every storage cell.
// No dependencies.
`timescale 1ns / 1ps

package spq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

  localparam logic ACT_ENQ = 1'b0;
  localparam logic ACT_DEQ = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } spq_status_e;

  typedef struct packed {
    logic                          enq;
    logic                          deq;
    logic signed [VALUE_WIDTH-1:0] value;
  } spq_cell_ctrl_t;

endpackage

[rtl/spq_if.sv]
// Valid/ready channel interfaces for the sorted priority queue: the request
// channel and the result channel. Depends on spq_pkg.
`timescale 1ns / 1ps

interface spq_in_if;
  import spq_pkg::*;
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic signed [VALUE_WIDTH-1:0] value;

  modport source (output valid, action, value, input ready);
  modport sink   (input valid, action, value, output ready);
endinterface

interface spq_out_if;
  import spq_pkg::*;
  logic                          valid;
  logic                          ready;
  spq_status_e                   status;
  logic signed [VALUE_WIDTH-1:0] front_value;
  logic                          is_empty;
  logic [COUNT_W-1:0]            entry_count;

  modport source (output valid, status, front_value, is_empty, entry_count, input ready);
  modport sink   (input valid, status, front_value, is_empty, entry_count, output ready);
endinterface

[rtl/spq_cell.sv]
// One storage cell of the sorted chain: holds one entry, compares it with the
// incoming value and shifts toward or away from its neighbors. Depends on spq_pkg.
`timescale 1ns / 1ps

module spq_cell
  import spq_pkg::*;
(
  input  logic                          clk_i,
  input  spq_cell_ctrl_t                ctrl_i,
  input  logic                          occupied_i,
  input  logic                          left_move_i,
  input  logic signed [VALUE_WIDTH-1:0] left_val_i,
  input  logic signed [VALUE_WIDTH-1:0] right_val_i,
  output logic                          move_o,
  output logic signed [VALUE_WIDTH-1:0] val_q_o,
  output logic signed [VALUE_WIDTH-1:0] val_d_o
);

  logic signed [VALUE_WIDTH-1:0] val_q;
  logic signed [VALUE_WIDTH-1:0] val_d;
  logic                          move;

  // An empty cell, or one holding a strictly larger value, gives way on enqueue.
  assign move = !occupied_i || (val_q > ctrl_i.value);

  always_comb begin
    val_d = val_q;
    if (ctrl_i.enq && move) begin
      // take the left neighbor if it also moves, else the new value lands here
      val_d = left_move_i ? left_val_i : ctrl_i.value;
    end else if (ctrl_i.deq) begin
      val_d = right_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign move_o  = move;
  assign val_q_o = val_q;
  assign val_d_o = val_d;

endmodule

[rtl/sorted_priority_queue.sv]
// Sorted priority queue, smallest value first, built as a row of storage cells.
// Each accepted request beat yields a result beat in the next cycle.
// Throughput: one request per cycle while results are taken; the whole cell row
// compares against the new value and shifts at once.
// Reset clears the entry count and the result valid; cell contents are not
// cleared and are only read below the count.
`timescale 1ns / 1ps

module sorted_priority_queue
  import spq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  spq_in_if.sink    in_i,
  spq_out_if.source out_o
);

  logic [COUNT_W-1:0] count_q, count_d;
  logic               out_valid_q;
  spq_status_e        status_q, status_d;
  logic signed [VALUE_WIDTH-1:0] front_q, front_d;

  logic fire, full, empty, enq_ok, deq_ok;
  spq_cell_ctrl_t ctrl;

  logic                          move   [QUEUE_DEPTH];
  logic signed [VALUE_WIDTH-1:0] cell_q [QUEUE_DEPTH];
  logic signed [VALUE_WIDTH-1:0] cell_d [QUEUE_DEPTH];

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign fire       = in_i.valid && in_i.ready;
  assign full       = (count_q == COUNT_W'(QUEUE_DEPTH));
  assign empty      = (count_q == '0);
  assign enq_ok     = fire && (in_i.action == ACT_ENQ) && !full;
  assign deq_ok     = fire && (in_i.action == ACT_DEQ) && !empty;

  assign ctrl.enq   = enq_ok;
  assign ctrl.deq   = deq_ok;
  assign ctrl.value = in_i.value;

  genvar gi;
  generate
    for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
      logic                          left_move;
      logic signed [VALUE_WIDTH-1:0] left_val;
      logic signed [VALUE_WIDTH-1:0] right_val;

      if (gi == 0) begin : g_head
        assign left_move = 1'b0;
        assign left_val  = '0;
      end else begin : g_body
        assign left_move = move[gi-1];
        assign left_val  = cell_q[gi-1];
      end

      if (gi == QUEUE_DEPTH - 1) begin : g_tail
        assign right_val = '0;
      end else begin : g_mid
        assign right_val = cell_q[gi+1];
      end

      spq_cell u_cell (
        .clk_i       (clk_i),
        .ctrl_i      (ctrl),
        .occupied_i  (COUNT_W'(gi) < count_q),
        .left_move_i (left_move),
        .left_val_i  (left_val),
        .right_val_i (right_val),
        .move_o      (move[gi]),
        .val_q_o     (cell_q[gi]),
        .val_d_o     (cell_d[gi])
      );
    end
  endgenerate

  always_comb begin
    count_d  = count_q;
    status_d = STATUS_OK;
    if (enq_ok) begin
      count_d = count_q + COUNT_W'(1);
    end else if (deq_ok) begin
      count_d = count_q - COUNT_W'(1);
    end
    if (in_i.action == ACT_ENQ && full) begin
      status_d = STATUS_FULL;
    end else if (in_i.action == ACT_DEQ && empty) begin
      status_d = STATUS_EMPTY;
    end
    front_d = (count_d != '0) ? cell_d[0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        count_q <= count_d;
      end
      if (in_i.ready) begin
        out_valid_q <= fire;
      end
    end
  end

  // hold the result payload until the beat is taken
  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q <= status_d;
      front_q  <= front_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = status_q;
  assign out_o.front_value = front_q;
  assign out_o.is_empty    = (count_q == '0);
  assign out_o.entry_count = count_q;

endmodule

[rtl/spq_checker.sv]
// Port-level checks for the sorted priority queue, bound to the top level.
// Depends on spq_pkg and sorted_priority_queue.
`timescale 1ns / 1ps

module spq_checker
  import spq_pkg::*;
(
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input spq_status_e                   status_i,
  input logic signed [VALUE_WIDTH-1:0] front_value_i,
  input logic                          is_empty_i,
  input logic [COUNT_W-1:0]            entry_count_i
);

  // every accepted request beat yields a result beat in the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> out_valid_i)
    else $error("no result beat after accepted request");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(status_i) && $stable(front_value_i) &&
       $stable(entry_count_i)))
    else $error("stalled result beat changed");

  a_empty_front: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && is_empty_i) |-> (front_value_i == '0 && entry_count_i == '0))
    else $error("empty queue shows a front value or count");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && status_i == STATUS_FULL) |->
      (entry_count_i == COUNT_W'(QUEUE_DEPTH)))
    else $error("full status with room left");

  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && status_i == STATUS_EMPTY) |-> is_empty_i)
    else $error("empty status on a non-empty queue");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .status_i      (out_o.status),
  .front_value_i (out_o.front_value),
  .is_empty_i    (out_o.is_empty),
  .entry_count_i (out_o.entry_count)
);
